[hdl/disparity_to_point_reproject_unit_defines.svh]
// Assertion macros used by the checker file dpr_chk.
`ifndef DISPARITY_TO_POINT_REPROJECT_UNIT_DEFINES_SVH
`define DISPARITY_TO_POINT_REPROJECT_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define DPR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define DPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/dpr_pkg.sv]
// ----------------------------------------------------------------------------
// dpr_pkg
// Shared constants, register indexes and saturation helper for the
// disparity reprojection block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int FB_W       = 24;
  localparam int FOCAL_W    = 20;
  localparam int DISP_W     = 16;
  localparam int COLOR_W    = 24;
  localparam int OUT_W      = 120;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_BASELINE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 3'd4;

  // Clamp a sign/magnitude value into 32-bit two's complement.
  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic [31:0] res;
    if (neg) begin
      if (mag >= 64'h0000_0000_8000_0000) res = 32'h8000_0000;
      else res = 32'(~mag[31:0] + 32'd1);
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) res = 32'h7FFF_FFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/disparity_to_point_reproject_unit.sv]
// Throughput: one request per cycle while the skid register is free, set by the one-bit-per-stage divider pipelines.
// Reset (rst_n low, synchronous): clears all valid bits and loads the camera
//   registers with their default calibration; no clearing pass is needed.
// ----------------------------------------------------------------------------
// disparity_to_point_reproject_unit
// Unless stalled, converts one disparity pixel per cycle into a saturated Q.8
// 3-D point with its colour: depth divider, offset/multiply stages, two offset
// dividers, saturation into an output register backed by a skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module disparity_to_point_reproject_unit #(
  parameter int COORD_BITS          = 12,
  parameter int DISPARITY_FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  // Input stream. tdata: column, row, disparity, blue, green, red (low bit up)
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [((2*COORD_BITS+47)/8)*8-1:0]        in_tdata,
  // Result stream. tdata: forward_depth, lateral_offset, up_offset,
  // blue_out, green_out, red_out (low bit up). tuser: point_valid
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [dpr_pkg::OUT_W-1:0]                 out_tdata,
  output logic [0:0]                                out_tuser,
  // Configuration write port
  input  logic                                      cfg_wr_en,
  input  logic [dpr_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [dpr_pkg::CFG_DATA_W-1:0]            cfg_wdata
);

  localparam int CB   = COORD_BITS;
  localparam int ZW   = dpr_pkg::FB_W + DISPARITY_FRAC_BITS;     // depth quotient width
  localparam int DW   = (CB + 8 > dpr_pkg::FOCAL_W) ? CB + 8 : dpr_pkg::FOCAL_W;
  localparam int PW   = DW + ZW;                                 // product width
  localparam int CW   = dpr_pkg::COLOR_W;
  localparam int S1_W = 2*CB + CW + 1;                           // col,row,colour,valid
  localparam int SX_W = ZW + CW + 2;                             // z,colour,valid,xneg

  // --------------------------------------------------------------------------
  // Camera registers, read directly; user must write only while pipeline is empty (unchecked).
  // --------------------------------------------------------------------------
  logic [dpr_pkg::FB_W-1:0]    fb_r;
  logic [dpr_pkg::FOCAL_W-1:0] fx_r, fy_r, cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= 24'd98402;
      fx_r <= 20'd184714;
      fy_r <= 20'd184714;
      cx_r <= 20'd156047;
      cy_r <= 20'd44251;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dpr_pkg::REG_FOCAL_BASELINE: fb_r <= cfg_wdata;
        dpr_pkg::REG_FOCAL_X:        fx_r <= cfg_wdata[dpr_pkg::FOCAL_W-1:0];
        dpr_pkg::REG_FOCAL_Y:        fy_r <= cfg_wdata[dpr_pkg::FOCAL_W-1:0];
        dpr_pkg::REG_CENTER_X:       cx_r <= cfg_wdata[dpr_pkg::FOCAL_W-1:0];
        dpr_pkg::REG_CENTER_Y:       cy_r <= cfg_wdata[dpr_pkg::FOCAL_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Whole pipeline advances while the skid register is free.
  logic sk_valid_r;
  logic ce;
  assign ce        = !sk_valid_r;
  assign in_tready = ce;

  // --------------------------------------------------------------------------
  // Unpack the request and start the depth division.
  // --------------------------------------------------------------------------
  logic [CB-1:0]                in_col, in_row;
  logic [dpr_pkg::DISP_W-1:0]   in_disp, disp_den;
  logic [CW-1:0]                in_bgr;
  logic                         in_acc;

  assign in_col   = in_tdata[CB-1:0];
  assign in_row   = in_tdata[2*CB-1:CB];
  assign in_disp  = in_tdata[2*CB+15:2*CB];
  assign in_bgr   = in_tdata[2*CB+39:2*CB+16];
  assign in_acc   = in_tvalid && in_tready;
  // Divide by one on zero disparity; the point is flagged invalid anyway.
  assign disp_den = (in_disp == '0) ? 16'd1 : in_disp;

  logic            d1_valid;
  logic [ZW-1:0]   d1_z;
  logic [S1_W-1:0] d1_side;

  dpr_div #(.NUM_W(ZW), .DEN_W(dpr_pkg::DISP_W), .SIDE_W(S1_W)) u_div_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (in_acc),
    .num      (ZW'(fb_r) << DISPARITY_FRAC_BITS),
    .den      (disp_den),
    .side_in  ({in_col, in_row, in_bgr, (in_disp != '0)}),
    .out_valid(d1_valid),
    .quo      (d1_z),
    .side_out (d1_side)
  );

  // --------------------------------------------------------------------------
  // Stage M1: offsets from the principal point as sign and magnitude.
  // --------------------------------------------------------------------------
  logic [CB-1:0] d1_col, d1_row;
  logic [CW-1:0] d1_bgr;
  logic          d1_pv;
  assign {d1_col, d1_row, d1_bgr, d1_pv} = d1_side;

  logic [DW-1:0] pos_x, pos_y, cen_x, cen_y;
  logic          xge, yge;
  logic [DW-1:0] dx_nxt, dy_nxt;

  always_comb begin
    pos_x  = DW'({d1_col, 8'h00});
    pos_y  = DW'({d1_row, 8'h00});
    cen_x  = DW'(cx_r);
    cen_y  = DW'(cy_r);
    xge    = (pos_x >= cen_x);
    yge    = (pos_y >= cen_y);
    dx_nxt = xge ? (pos_x - cen_x) : (cen_x - pos_x);
    dy_nxt = yge ? (pos_y - cen_y) : (cen_y - pos_y);
  end

  logic          m1_v_r;
  logic [ZW-1:0] m1_z_r;
  logic [CW-1:0] m1_bgr_r;
  logic          m1_pv_r, m1_xn_r, m1_yn_r;
  logic [DW-1:0] m1_dx_r, m1_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (ce) begin
      m1_v_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m1_z_r   <= d1_z;
      m1_bgr_r <= d1_bgr;
      m1_pv_r  <= d1_pv;
      m1_xn_r  <= !xge;
      m1_yn_r  <= !yge;
      m1_dx_r  <= dx_nxt;
      m1_dy_r  <= dy_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage M2: offset magnitude times depth.
  // --------------------------------------------------------------------------
  logic [PW-1:0] px_nxt, py_nxt;
  assign px_nxt = PW'(m1_dx_r) * PW'(m1_z_r);
  assign py_nxt = PW'(m1_dy_r) * PW'(m1_z_r);

  logic          m2_v_r;
  logic [PW-1:0] m2_px_r, m2_py_r;
  logic [ZW-1:0] m2_z_r;
  logic [CW-1:0] m2_bgr_r;
  logic          m2_pv_r, m2_xn_r, m2_yn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (ce) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m2_px_r  <= px_nxt;
      m2_py_r  <= py_nxt;
      m2_z_r   <= m1_z_r;
      m2_bgr_r <= m1_bgr_r;
      m2_pv_r  <= m1_pv_r;
      m2_xn_r  <= m1_xn_r;
      m2_yn_r  <= m1_yn_r;
    end
  end

  // --------------------------------------------------------------------------
  // Offset dividers by the focal lengths (zero focal length used as one).
  // --------------------------------------------------------------------------
  logic [dpr_pkg::FOCAL_W-1:0] fx_den, fy_den;
  assign fx_den = (fx_r == '0) ? 20'd1 : fx_r;
  assign fy_den = (fy_r == '0) ? 20'd1 : fy_r;

  logic            dx_valid, dy_valid;
  logic [PW-1:0]   xq, yq;
  logic [SX_W-1:0] dx_side;
  logic [0:0]      dy_side;

  dpr_div #(.NUM_W(PW), .DEN_W(dpr_pkg::FOCAL_W), .SIDE_W(SX_W)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (m2_v_r),
    .num      (m2_px_r),
    .den      (fx_den),
    .side_in  ({m2_z_r, m2_bgr_r, m2_pv_r, m2_xn_r}),
    .out_valid(dx_valid),
    .quo      (xq),
    .side_out (dx_side)
  );

  dpr_div #(.NUM_W(PW), .DEN_W(dpr_pkg::FOCAL_W), .SIDE_W(1)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (m2_v_r),
    .num      (m2_py_r),
    .den      (fy_den),
    .side_in  (m2_yn_r),
    .out_valid(dy_valid),
    .quo      (yq),
    .side_out (dy_side)
  );

  // --------------------------------------------------------------------------
  // Saturate and pack the result.
  // --------------------------------------------------------------------------
  logic [ZW-1:0] f_z;
  logic [CW-1:0] f_bgr;
  logic          f_pv, f_xn;
  assign {f_z, f_bgr, f_pv, f_xn} = dx_side;

  logic                 p_valid;
  logic [31:0]          p_fwd, p_lat, p_up;
  logic [dpr_pkg::OUT_W:0] p_data;

  always_comb begin
    p_valid = dx_valid && dy_valid;
    p_fwd   = '0;
    p_lat   = '0;
    p_up    = '0;
    if (f_pv) begin
      p_fwd = dpr_pkg::sat32(1'b0, 64'(f_z));
      p_lat = dpr_pkg::sat32(f_xn && (xq != '0), 64'(xq));
      // Up is minus the vertical offset: a downward row gives a negative value.
      p_up  = dpr_pkg::sat32(!dy_side[0] && (yq != '0), 64'(yq));
    end
    p_data = {f_pv, f_bgr, p_up, p_lat, p_fwd};
  end

  // --------------------------------------------------------------------------
  // Output register with skid register: hold a result the pipeline pushed
  // while the consumer stalled, then stop the pipeline until it drains.
  // --------------------------------------------------------------------------
  logic                    out_valid_r;
  logic [dpr_pkg::OUT_W:0] out_data_r, sk_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (sk_valid_r) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= 1'b0;
      end else begin
        out_valid_r <= p_valid;
      end
    end else if (p_valid && ce) begin
      sk_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      out_data_r <= sk_valid_r ? sk_data_r : p_data;
    end else if (p_valid && ce) begin
      sk_data_r <= p_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r[dpr_pkg::OUT_W-1:0];
  assign out_tuser  = out_data_r[dpr_pkg::OUT_W];

endmodule

`default_nettype wire

[hdl/dpr_div.sv]
// ----------------------------------------------------------------------------
// dpr_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module dpr_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ce,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic              v_r    [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  q_r    [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic              vin;
    logic [DEN_W-1:0]  rin;
    logic [NUM_W-1:0]  qin;
    logic [DEN_W-1:0]  din;
    logic [SIDE_W-1:0] sin;
    logic [DEN_W:0]    t;
    logic              ge;
    logic [DEN_W-1:0]  rem_nxt;
    logic [NUM_W-1:0]  q_nxt;

    if (g == 0) begin : g_first
      assign vin = in_valid;
      assign rin = '0;
      assign qin = num;
      assign din = den;
      assign sin = side_in;
    end else begin : g_rest
      assign vin = v_r[g-1];
      assign rin = rem_r[g-1];
      assign qin = q_r[g-1];
      assign din = den_r[g-1];
      assign sin = side_r[g-1];
    end

    // Shift in the next numerator bit, subtract when it fits.
    always_comb begin
      t       = {rin, qin[NUM_W-1]};
      ge      = (t >= {1'b0, din});
      rem_nxt = ge ? DEN_W'(t - {1'b0, din}) : t[DEN_W-1:0];
      q_nxt   = {qin[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (ce) begin
        v_r[g] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[g]  <= rem_nxt;
        q_r[g]    <= q_nxt;
        den_r[g]  <= din;
        side_r[g] <= sin;
      end
    end
  end

  assign out_valid = v_r[NUM_W-1];
  assign quo       = q_r[NUM_W-1];
  assign side_out  = side_r[NUM_W-1];

endmodule

`default_nettype wire

[hdl/dpr_chk.sv]
// ----------------------------------------------------------------------------
// dpr_chk
// Port-level checks on the result stream of the reprojection block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "disparity_to_point_reproject_unit_defines.svh"

module dpr_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [dpr_pkg::OUT_W-1:0]   out_tdata,
  input wire logic [0:0]                  out_tuser
);

  `DPR_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready |=> out_tvalid), "result dropped while stalled")
  `DPR_ASSERT(a_out_stable, clk, rst_n, (out_tvalid && !out_tready |=> $stable(out_tdata)), "stalled result changed")
  `DPR_ASSERT(a_invalid_zero, clk, rst_n, (out_tvalid && !out_tuser[0] |-> out_tdata[95:0] == 96'd0), "invalid point has nonzero coordinates")
  `DPR_ASSERT(a_depth_pos, clk, rst_n, (out_tvalid |-> !out_tdata[31]), "negative depth")
  `DPR_ASSERT_ALWAYS(a_reset_empty, clk, (!rst_n |=> !out_tvalid), "result after reset")

endmodule

bind disparity_to_point_reproject_unit dpr_chk u_dpr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

`default_nettype wire
